// ----- hw/rtl/csvp_pkg.sv -----
// Package for the CSV byte stream parser: widths, register map, parse modes,
// status codes and the config/result structs. No dependencies.
package csvp_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int POSITION_WIDTH = 32;
    localparam int ADDR_WIDTH     = 4;
    localparam int DATA_WIDTH     = 32;

    localparam logic [1:0] REG_DELIMITER = 2'd0;
    localparam logic [1:0] REG_QUOTE     = 2'd1;
    localparam logic [1:0] REG_NEWLINE   = 2'd2;
    localparam logic [1:0] REG_PEDANTIC  = 2'd3;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;
    localparam logic [7:0] NEWLINE_RESET   = 8'd10;

    typedef enum logic [3:0] {
        MODE_START    = 4'b0001,
        MODE_QUOTED   = 4'b0010,
        MODE_UNQUOTED = 4'b0100,
        MODE_ENDQUOTE = 4'b1000
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_QUOTE_UNQ   = 3'd1,
        ST_JUNK        = 3'd2,
        ST_WIDTH       = 3'd3,
        ST_UNTERM      = 3'd4,
        ST_HALTED      = 3'd5
    } t_status;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] newline_char;
        logic       pedantic_mode;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  char_out;
        logic        char_valid;
        logic        field_end;
        logic        row_end;
        logic [15:0] row_fields;
        logic        input_done;
        t_status     status;
        logic [31:0] byte_position;
    } t_result;

endpackage

// ----- hw/rtl/csvp_ifs.sv -----
// Stream interfaces of the CSV parser: byte requests in, parse results out.
// Depends on nothing.
interface csvp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       end_of_input;

    modport source (output valid, byte_in, end_of_input, input ready);
    modport sink   (input valid, byte_in, end_of_input, output ready);
endinterface

interface csvp_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_out;
    logic        char_valid;
    logic        field_end;
    logic        row_end;
    logic [15:0] row_fields;
    logic        input_done;
    logic [2:0]  status;
    logic [31:0] byte_position;

    modport source (output valid, char_out, char_valid, field_end, row_end, row_fields,
                    input_done, status, byte_position, input ready);
    modport sink   (input valid, char_out, char_valid, field_end, row_end, row_fields,
                    input_done, status, byte_position, output ready);
endinterface

// ----- hw/rtl/csvp_regs.sv -----
// APB configuration registers of the CSV parser.
// Depends on csvp_pkg.
module csvp_regs
    import csvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= DELIMITER_RESET;
            r_cfg.quote_char     <= QUOTE_RESET;
            r_cfg.newline_char   <= NEWLINE_RESET;
            r_cfg.pedantic_mode  <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DELIMITER: r_cfg.delimiter_char <= pwdata[7:0];
                REG_QUOTE:     r_cfg.quote_char     <= pwdata[7:0];
                REG_NEWLINE:   r_cfg.newline_char   <= pwdata[7:0];
                REG_PEDANTIC:  r_cfg.pedantic_mode  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_DELIMITER: prdata = DATA_WIDTH'(r_cfg.delimiter_char);
            REG_QUOTE:     prdata = DATA_WIDTH'(r_cfg.quote_char);
            REG_NEWLINE:   prdata = DATA_WIDTH'(r_cfg.newline_char);
            REG_PEDANTIC:  prdata = DATA_WIDTH'(r_cfg.pedantic_mode);
            default:       prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/csvp_core.sv -----
// Per-byte parse step of the CSV parser: parse state registers and the
// next-state / result logic. Depends on csvp_pkg.
module csvp_core
    import csvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte_in,
    input  logic       i_end_of_input,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_mode                     r_mode, n_mode;
    logic                      r_at_row_start, n_at_row_start;
    logic [COUNT_WIDTH-1:0]    r_field_cnt, n_field_cnt;
    logic [COUNT_WIDTH-1:0]    r_first_width, n_first_width;
    logic                      r_first_seen, n_first_seen;
    logic                      r_halted, n_halted;
    logic [POSITION_WIDTH-1:0] r_pos, n_pos;

    logic                      is_quote, is_delim, is_newline;
    logic                      end_fld, end_row;
    logic [COUNT_WIDTH-1:0]    field_inc;
    logic [POSITION_WIDTH-1:0] pos_inc;
    t_result                   res;

    assign is_quote   = (i_byte_in == i_cfg.quote_char);
    assign is_delim   = (i_byte_in == i_cfg.delimiter_char);
    assign is_newline = (i_byte_in == i_cfg.newline_char);
    assign field_inc  = (&r_field_cnt) ? r_field_cnt : r_field_cnt + 1'b1;
    assign pos_inc    = (&r_pos) ? r_pos : r_pos + 1'b1;
    assign o_result   = res;

    always_comb begin
        n_mode         = r_mode;
        n_at_row_start = r_at_row_start;
        n_field_cnt    = r_field_cnt;
        n_first_width  = r_first_width;
        n_first_seen   = r_first_seen;
        n_halted       = r_halted;
        n_pos          = r_pos;
        end_fld        = 1'b0;
        end_row        = 1'b0;

        res               = '0;
        res.status        = ST_OK;
        res.row_fields    = 16'(r_field_cnt);
        res.byte_position = 32'(r_pos);

        if (r_halted) begin
            res.status = ST_HALTED;
        end else if (i_end_of_input) begin
            res.input_done = 1'b1;
            n_halted       = 1'b1;
            if (!r_at_row_start) begin
                if (r_mode == MODE_QUOTED) begin
                    res.status = ST_UNTERM;
                end else begin
                    end_row = 1'b1;
                end
            end
        end else begin
            n_pos          = pos_inc;
            n_at_row_start = 1'b0;
            unique case (r_mode)
                MODE_START: begin
                    if (is_quote) begin
                        n_mode = MODE_QUOTED;
                    end else if (is_delim) begin
                        end_fld = 1'b1;
                    end else if (is_newline) begin
                        end_row = 1'b1;
                    end else begin
                        n_mode         = MODE_UNQUOTED;
                        res.char_out   = i_byte_in;
                        res.char_valid = 1'b1;
                    end
                end
                MODE_QUOTED: begin
                    if (is_quote) begin
                        n_mode = MODE_ENDQUOTE;
                    end else begin
                        res.char_out   = i_byte_in;
                        res.char_valid = 1'b1;
                    end
                end
                MODE_UNQUOTED: begin
                    if (is_delim) begin
                        end_fld = 1'b1;
                    end else if (is_newline) begin
                        end_row = 1'b1;
                    end else if (is_quote) begin
                        res.status = ST_QUOTE_UNQ;
                        n_halted   = 1'b1;
                    end else begin
                        res.char_out   = i_byte_in;
                        res.char_valid = 1'b1;
                    end
                end
                MODE_ENDQUOTE: begin
                    if (is_delim) begin
                        end_fld = 1'b1;
                    end else if (is_newline) begin
                        end_row = 1'b1;
                    end else if (is_quote) begin
                        // doubled quote inside a quoted field
                        n_mode         = MODE_QUOTED;
                        res.char_out   = i_byte_in;
                        res.char_valid = 1'b1;
                    end else begin
                        res.status = ST_JUNK;
                        n_halted   = 1'b1;
                    end
                end
                default: n_mode = MODE_START;
            endcase
        end

        if (end_fld || end_row) begin
            n_field_cnt    = field_inc;
            res.row_fields = 16'(field_inc);
            n_mode         = MODE_START;
            n_at_row_start = 1'b0;
            if (!end_row) begin
                res.field_end = 1'b1;
            end else if (r_first_seen && i_cfg.pedantic_mode
                         && (field_inc != r_first_width)) begin
                res.status = ST_WIDTH;
                n_halted   = 1'b1;
            end else begin
                if (!r_first_seen) begin
                    n_first_seen  = 1'b1;
                    n_first_width = field_inc;
                end
                res.field_end  = 1'b1;
                res.row_end    = 1'b1;
                n_field_cnt    = '0;
                n_at_row_start = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_START;
            r_at_row_start <= 1'b1;
            r_field_cnt    <= '0;
            r_first_width  <= '0;
            r_first_seen   <= 1'b0;
            r_halted       <= 1'b0;
            r_pos          <= '0;
        end else if (i_accept) begin
            r_mode         <= n_mode;
            r_at_row_start <= n_at_row_start;
            r_field_cnt    <= n_field_cnt;
            r_first_width  <= n_first_width;
            r_first_seen   <= n_first_seen;
            r_halted       <= n_halted;
            r_pos          <= n_pos;
        end
    end

endmodule

// ----- hw/rtl/csv_byte_stream_parser_top.sv -----
// Top level of the CSV byte stream parser: config registers, parse core and
// result register. Depends on csvp_pkg, csvp_ifs, csvp_regs, csvp_core.
//
// Usage:
//   i_byte_if: one request per byte of CSV text, or one end-of-input request.
//   o_res_if:  exactly one result per request, in order.
//   APB port:  delimiter (0x0), quote (0x4), newline (0x8), pedantic (0xC);
//              write only while no request is in flight.
// A request accepted at a clock edge has its result valid in the cycle after.
// Throughput: one byte per cycle while the receiver takes results, set by the
// single parse step between the request handshake and the result register.
// The request side stays ready while the result register is empty or being
// taken in the same cycle; a stalled receiver holds the result and blocks
// further requests until it is taken.
// Reset (synchronous, active low) restores default characters, clears the
// parse state and empties the result register. After an error or an
// end-of-input request the parser answers every request with status halted
// until the next reset.
module csv_byte_stream_parser_top
    import csvp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csvp_byte_if.sink             i_byte_if,
    csvp_res_if.source            o_res_if,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    t_cfg    cfg;
    t_result step_res;
    t_result r_out;
    logic    r_out_valid;
    logic    in_accept;

    csvp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign i_byte_if.ready = !r_out_valid || o_res_if.ready;
    assign in_accept       = i_byte_if.valid && i_byte_if.ready;

    csvp_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_byte_in      (i_byte_if.byte_in),
        .i_end_of_input (i_byte_if.end_of_input),
        .i_cfg          (cfg),
        .o_result       (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= step_res;
        end
    end

    assign o_res_if.valid         = r_out_valid;
    assign o_res_if.char_out      = r_out.char_out;
    assign o_res_if.char_valid    = r_out.char_valid;
    assign o_res_if.field_end     = r_out.field_end;
    assign o_res_if.row_end       = r_out.row_end;
    assign o_res_if.row_fields    = r_out.row_fields;
    assign o_res_if.input_done    = r_out.input_done;
    assign o_res_if.status        = r_out.status;
    assign o_res_if.byte_position = r_out.byte_position;

    a_row_end_ends_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.row_end |-> r_out.field_end && !r_out.char_valid)
        else $error("row end without field end");

    a_eoi_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_byte_if.end_of_input |=>
            r_out_valid && (r_out.input_done || r_out.status == ST_HALTED))
        else $error("end of input request not answered");

    a_error_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out.status == ST_QUOTE_UNQ || r_out.status == ST_JUNK) |->
            !r_out.field_end && !r_out.char_valid && !r_out.input_done)
        else $error("syntax error result carries data");

endmodule
